// ===== src/vct_pkg.sv =====
// ----------------------------------------------------------------------------
// vct_pkg
// Shared types and constants for the vector clock table.
// ----------------------------------------------------------------------------
package vct_pkg;

  localparam int SITES_DEF = 64;
  localparam int SITE_W    = 6;
  localparam int CLK_W     = 32;
  localparam int LEN_W     = 7;
  localparam int OP_W      = 3;
  // highest number of sites the site field can address
  localparam int MAX_SITES = 2 ** SITE_W;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 3'd0,
    OP_SET    = 3'd1,
    OP_MERGE  = 3'd2,
    OP_QUERY  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture item, read its entry
    logic exec;   // apply the operation
    logic scan;   // step the maximum search
    logic fin;    // close the maximum search
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic need_scan;
    logic scan_end;
  } sts_t;

endpackage

// ===== src/vector_clock_table_unit.sv =====
// The accepting edge captures the item and reads its entry; the execute state
// applies it and the result strobe is registered after that. A set that lowers
// the entry holding the maximum adds a walk over the used length first. Items
// never overlap on the counter store's single read port. Clear needs no walk (valid flags).
// Reset: async active low; table empty, length and maximum zero, no walk.
// The receiver cannot stall: result_valid_o holds for exactly one cycle.
// ----------------------------------------------------------------------------
// vector_clock_table_unit
// Vector clock with per-site counters, used length and running maximum.
// ----------------------------------------------------------------------------
module vector_clock_table_unit #(
  parameter int SITES = vct_pkg::SITES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [vct_pkg::OP_W-1:0]   op_i,
  input  logic [vct_pkg::SITE_W-1:0] site_i,
  input  logic [vct_pkg::CLK_W-1:0]  clock_req_i,
  output logic                       result_valid_o,
  output logic [vct_pkg::CLK_W-1:0]  prior_clock_o,
  output logic                       is_behind_o,
  output logic [vct_pkg::CLK_W-1:0]  max_clock_o,
  output logic [vct_pkg::LEN_W-1:0]  used_length_o
);
  import vct_pkg::*;

  ctl_t ctl;
  sts_t sts;

  vct_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy)
  );

  vct_datapath #(
    .SITES(SITES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .op_i          (op_i),
    .site_i        (site_i),
    .clock_req_i   (clock_req_i),
    .result_valid_o(result_valid_o),
    .prior_clock_o (prior_clock_o),
    .is_behind_o   (is_behind_o),
    .max_clock_o   (max_clock_o),
    .used_length_o (used_length_o)
  );

endmodule

// ===== src/vct_ctrl.sv =====
// ----------------------------------------------------------------------------
// vct_ctrl
// Sequencer: accept, execute, optional maximum search over the table.
// ----------------------------------------------------------------------------
module vct_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  vct_pkg::sts_t sts_i,
  output vct_pkg::ctl_t ctl_o,
  output logic          busy_o
);
  import vct_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = sts_i.need_scan ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if (sts_i.scan_end) begin
          ctl_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          ctl_o.scan = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/vct_datapath.sv =====
// ----------------------------------------------------------------------------
// vct_datapath
// Counter store, per-entry valid flags, length and maximum registers.
// ----------------------------------------------------------------------------
module vct_datapath #(
  parameter int SITES = vct_pkg::SITES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  vct_pkg::ctl_t              ctl_i,
  output vct_pkg::sts_t              sts_o,
  input  logic [vct_pkg::OP_W-1:0]   op_i,
  input  logic [vct_pkg::SITE_W-1:0] site_i,
  input  logic [vct_pkg::CLK_W-1:0]  clock_req_i,
  output logic                       result_valid_o,
  output logic [vct_pkg::CLK_W-1:0]  prior_clock_o,
  output logic                       is_behind_o,
  output logic [vct_pkg::CLK_W-1:0]  max_clock_o,
  output logic [vct_pkg::LEN_W-1:0]  used_length_o
);
  import vct_pkg::*;

  localparam int DEPTH = (SITES < MAX_SITES) ? SITES : MAX_SITES;
  localparam int AW    = $clog2(DEPTH);

  logic [CLK_W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]  vbit_q;

  logic [OP_W-1:0]   op_q;
  logic [SITE_W-1:0] site_q;
  logic [CLK_W-1:0]  creq_q;
  logic [CLK_W-1:0]  rd_q;
  logic              rd_vbit_q;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [CLK_W-1:0]  max_q, max_d;
  logic [CLK_W-1:0]  prior_q;
  logic              behind_q;
  logic              done_q;
  logic [LEN_W-1:0]  cnt_q;
  logic              rv_q;
  logic [CLK_W-1:0]  acc_q;

  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  logic              clr;
  logic              site_ok;
  logic              in_len;
  logic [CLK_W-1:0]  prior;
  logic              behind;
  logic              need_scan;
  logic [LEN_W-1:0]  site_len;

  // read port: item entry on load, table walk during scan
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(site_i);
    if (ctl_i.load) begin
      rd_en = 1'b1;
    end else if (ctl_i.scan && (cnt_q < len_q)) begin
      rd_en   = 1'b1;
      rd_addr = AW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= creq_q;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_vbit_q <= vbit_q[rd_addr];
    end
  end

  // entry never written since clear reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbit_q <= '0;
    end else if (clr) begin
      vbit_q <= '0;
    end else if (wr_en) begin
      vbit_q[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    site_ok   = {1'b0, site_q} < LEN_W'(DEPTH);
    in_len    = {1'b0, site_q} < len_q;
    site_len  = {1'b0, site_q} + LEN_W'(1);
    wr_addr   = AW'(site_q);
    prior     = (site_ok && in_len && rd_vbit_q) ? rd_q : '0;
    behind    = prior < creq_q;
    len_d     = len_q;
    max_d     = max_q;
    wr_en     = 1'b0;
    clr       = 1'b0;
    need_scan = 1'b0;
    case (op_q)
      OP_UPDATE: begin
        if (site_ok) begin
          if (!in_len && (creq_q != '0)) len_d = site_len;
          if (behind) begin
            wr_en = 1'b1;
            if (max_q < creq_q) max_d = creq_q;
          end
        end
      end
      OP_SET: begin
        if (site_ok && (in_len || (creq_q != '0))) begin
          if (!in_len) len_d = site_len;
          wr_en = 1'b1;
          if ((prior == max_q) && (creq_q < prior)) begin
            need_scan = 1'b1;
          end else if (max_q < creq_q) begin
            max_d = creq_q;
          end
        end
      end
      OP_MERGE: begin
        if (site_ok) begin
          if (!in_len) len_d = site_len;
          if (behind) begin
            wr_en = 1'b1;
            if (max_q < creq_q) max_d = creq_q;
          end
        end
      end
      OP_CLEAR: begin
        clr   = 1'b1;
        len_d = '0;
        max_d = '0;
      end
      default: begin
      end
    endcase
    wr_en     = wr_en && ctl_i.exec;
    clr       = clr && ctl_i.exec;
    need_scan = need_scan && ctl_i.exec;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q   <= op_i;
      site_q <= site_i;
      creq_q <= clock_req_i;
    end
    if (ctl_i.exec) begin
      prior_q  <= prior;
      behind_q <= behind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      max_q  <= '0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rv_q   <= 1'b0;
      acc_q  <= '0;
    end else begin
      done_q <= (ctl_i.exec && !need_scan) || ctl_i.fin;
      if (ctl_i.exec) begin
        len_q <= len_d;
        max_q <= max_d;
        cnt_q <= '0;
        rv_q  <= 1'b0;
        acc_q <= '0;
      end else if (ctl_i.scan) begin
        rv_q <= rd_en;
        if (rd_en) cnt_q <= cnt_q + LEN_W'(1);
        // rd_q holds the read issued on the previous scan step, flagged by rv_q
        if (rv_q && rd_vbit_q && (rd_q > acc_q)) acc_q <= rd_q;
      end else if (ctl_i.fin) begin
        max_q <= acc_q;
      end
    end
  end

  assign sts_o.need_scan = need_scan;
  assign sts_o.scan_end  = (cnt_q >= len_q) && !rv_q;

  assign result_valid_o = done_q;
  assign prior_clock_o  = prior_q;
  assign is_behind_o    = behind_q;
  assign max_clock_o    = max_q;
  assign used_length_o  = len_q;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vector_clock_table_unit: a directed table of items,
// then paced random traffic. Each result is checked against a shadow table or, for typed directed rows, their values.
// ----------------------------------------------------------------------------
module tb;
  import vct_pkg::*;

  // op codes with no operation behind them; the block treats them as a query
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 80;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [CLK_W-1:0] prior;
    logic             behind;
    logic [CLK_W-1:0] maxc;
    logic [LEN_W-1:0] len;
  } stamp_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SITE_W-1:0] site;
    logic [CLK_W-1:0]  clk;
    logic              typed;
    stamp_t            want;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   op_i;
  logic [SITE_W-1:0] site_i;
  logic [CLK_W-1:0]  clock_req_i;
  logic              result_valid_o;
  logic [CLK_W-1:0]  prior_clock_o;
  logic              is_behind_o;
  logic [CLK_W-1:0]  max_clock_o;
  logic [LEN_W-1:0]  used_length_o;

  vector_clock_table_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .site_i         (site_i),
    .clock_req_i    (clock_req_i),
    .result_valid_o (result_valid_o),
    .prior_clock_o  (prior_clock_o),
    .is_behind_o    (is_behind_o),
    .max_clock_o    (max_clock_o),
    .used_length_o  (used_length_o)
  );

  // shadow copy of the table
  logic [CLK_W-1:0] shadow_clocks [SITES_DEF];
  logic [LEN_W-1:0] shadow_len;
  logic [CLK_W-1:0] shadow_max;

  stamp_t   stamp_q [$];
  dir_row_t directed_rows [$];

  int n_errors;
  int n_items;
  int n_checked;
  int n_walks;
  int n_clears;
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, stamp_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string field, input logic [CLK_W-1:0] want,
                        input logic [CLK_W-1:0] got);
    if (n_errors < PRINT_CAP)
      $display("ERROR cycle %0d: %s expected %h got %h", cycle_count, field, want, got);
    n_errors++;
  endtask

  function automatic stamp_t vclock_step(input logic [OP_W-1:0] op,
                                         input logic [SITE_W-1:0] site,
                                         input logic [CLK_W-1:0] c);
    stamp_t           r;
    logic [CLK_W-1:0] prior;
    logic [CLK_W-1:0] m;
    logic [LEN_W-1:0] ext;
    ext   = LEN_W'(site) + 1'b1;
    prior = (LEN_W'(site) < shadow_len) ? shadow_clocks[site] : '0;
    case (op)
      OP_UPDATE: begin
        if (LEN_W'(site) >= shadow_len && c != '0) shadow_len = ext;
        if (prior < c) begin
          shadow_clocks[site] = c;
          if (shadow_max < c) shadow_max = c;
        end
      end
      OP_SET: begin
        // zero written beyond the length is dropped
        if (LEN_W'(site) < shadow_len || c != '0) begin
          if (LEN_W'(site) >= shadow_len) shadow_len = ext;
          shadow_clocks[site] = c;
          if (prior == shadow_max && c < prior) begin
            m = '0;
            for (int i = 0; i < SITES_DEF; i++)
              if (i < shadow_len && shadow_clocks[i] > m) m = shadow_clocks[i];
            shadow_max = m;
            n_walks++;
          end else if (shadow_max < c) begin
            shadow_max = c;
          end
        end
      end
      OP_MERGE: begin
        if (LEN_W'(site) >= shadow_len) shadow_len = ext;
        if (c > prior) begin
          shadow_clocks[site] = c;
          if (shadow_max < c) shadow_max = c;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SITES_DEF; i++) shadow_clocks[i] = '0;
        shadow_len = '0;
        shadow_max = '0;
        n_clears++;
      end
      default: ;
    endcase
    r.prior  = prior;
    r.behind = prior < c;
    r.maxc   = shadow_max;
    r.len    = shadow_len;
    return r;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    stamp_t w;
    if (rst_ni && result_valid_o) begin
      if (stamp_q.size() == 0) begin
        report("unexpected result, prior_clock", '0, prior_clock_o);
      end else begin
        w = stamp_q.pop_front();
        n_checked++;
        if (prior_clock_o !== w.prior)  report("prior_clock", w.prior, prior_clock_o);
        if (is_behind_o !== w.behind)
          report("is_behind", CLK_W'(w.behind), CLK_W'(is_behind_o));
        if (max_clock_o !== w.maxc)     report("max_clock", w.maxc, max_clock_o);
        if (used_length_o !== w.len)
          report("used_length", CLK_W'(w.len), CLK_W'(used_length_o));
      end
    end
  end

  task automatic issue(input logic [OP_W-1:0] op, input logic [SITE_W-1:0] site,
                       input logic [CLK_W-1:0] c, input bit typed, input stamp_t want);
    stamp_t pred;
    @(negedge clk_i);
    start       <= 1'b1;
    op_i        <= op;
    site_i      <= site;
    clock_req_i <= c;
    do @(posedge clk_i); while (busy);
    pred = vclock_step(op, site, c);
    stamp_q.push_back(typed ? want : pred);
    n_items++;
  endtask

  task automatic rest(input int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (stamp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic dir_row_t row(input logic [OP_W-1:0] op, input logic [SITE_W-1:0] site,
                                   input logic [CLK_W-1:0] c, input bit typed,
                                   input logic [CLK_W-1:0] prior, input bit behind,
                                   input logic [CLK_W-1:0] maxc, input logic [LEN_W-1:0] len);
    dir_row_t d;
    d.op          = op;
    d.site        = site;
    d.clk         = c;
    d.typed       = typed;
    d.want.prior  = prior;
    d.want.behind = behind;
    d.want.maxc   = maxc;
    d.want.len    = len;
    return d;
  endfunction

  task automatic random_item();
    logic [OP_W-1:0]   op;
    logic [SITE_W-1:0] site;
    logic [CLK_W-1:0]  c;
    logic [CLK_W-1:0]  base;
    int                pick;
    int                top;
    int                holders [$];
    pick = $urandom_range(0, 99);
    if (pick < 32)      op = OP_UPDATE;
    else if (pick < 60) op = OP_SET;
    else if (pick < 78) op = OP_MERGE;
    else if (pick < 90) op = OP_QUERY;
    else if (pick < 93) op = OP_CLEAR;
    else if (pick < 95) op = OP_SPARE_5;
    else if (pick < 97) op = OP_SPARE_6;
    else                op = OP_SPARE_7;

    top  = (shadow_len < 63) ? int'(shadow_len) : 63;
    site = ($urandom_range(0, 99) < 65) ? SITE_W'($urandom_range(0, top))
                                        : SITE_W'($urandom_range(0, 63));
    base = (LEN_W'(site) < shadow_len) ? shadow_clocks[site] : '0;

    pick = $urandom_range(0, 99);
    if (pick < 25)      c = $urandom_range(0, 15);
    else if (pick < 45) c = base + $urandom_range(0, 4) - 2;
    else if (pick < 55) c = shadow_max;
    else if (pick < 80) c = $urandom();
    else                c = 32'hFFFF_FFFF - $urandom_range(0, 7);

    // lower the entry holding the maximum so the block walks the table
    if (op == OP_SET && shadow_max != '0 && $urandom_range(0, 2) == 0) begin
      for (int i = 0; i < SITES_DEF; i++)
        if (i < shadow_len && shadow_clocks[i] == shadow_max) holders.push_back(i);
      if (holders.size() != 0) begin
        site = SITE_W'(holders[$urandom_range(0, holders.size() - 1)]);
        c    = $urandom_range(0, shadow_max - 1);
      end
    end
    issue(op, site, c, 1'b0, '0);
  endtask

  initial begin
    int idle_pct [4];
    dir_row_t d;
    idle_pct = '{0, 82, 10, 0};
    start       = 1'b0;
    op_i        = OP_QUERY;
    site_i      = '0;
    clock_req_i = '0;
    rst_ni      = 1'b0;
    n_errors    = 0;
    n_items     = 0;
    n_checked   = 0;
    n_walks     = 0;
    n_clears    = 0;
    cycle_count = 0;
    for (int i = 0; i < SITES_DEF; i++) shadow_clocks[i] = '0;
    shadow_len = '0;
    shadow_max = '0;

    directed_rows.push_back(row(OP_QUERY,   0,  32'h0,         1, 32'h0,         0, 32'h0, 0));
    directed_rows.push_back(row(OP_QUERY,   63, 32'hFFFF_FFFF, 1, 32'h0,         1, 32'h0, 0));
    directed_rows.push_back(row(OP_SET,     10, 32'h0,         1, 32'h0,         0, 32'h0, 0));
    directed_rows.push_back(row(OP_UPDATE,  5,  32'h0,         1, 32'h0,         0, 32'h0, 0));
    directed_rows.push_back(row(OP_MERGE,   3,  32'h0,         1, 32'h0,         0, 32'h0, 4));
    directed_rows.push_back(row(OP_UPDATE,  63, 32'hFFFF_FFFF, 1, 32'h0, 1, 32'hFFFF_FFFF, 64));
    directed_rows.push_back(row(OP_UPDATE,  0,  32'h5,         1, 32'h0, 1, 32'hFFFF_FFFF, 64));
    directed_rows.push_back(row(OP_SET,     63, 32'h7,         1, 32'hFFFF_FFFF, 0, 32'h7, 64));
    directed_rows.push_back(row(OP_SET,     0,  32'h1,         0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_UPDATE,  0,  32'h3,         0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_UPDATE,  0,  32'h2,         0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_MERGE,   20, 32'd100,       0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_SET,     20, 32'h0,         0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_SPARE_5, 20, 32'h1,         0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_SPARE_6, 63, 32'hFFFF_FFFF, 0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_SPARE_7, 0,  32'h0,         0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_SET,     1,  32'hFFFF_FFFF, 0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_QUERY,   1,  32'h0,         0, '0, 0, '0, '0));
    directed_rows.push_back(row(OP_CLEAR,   63, 32'h8,         1, 32'h7,         1, 32'h0, 0));
    directed_rows.push_back(row(OP_QUERY,   63, 32'h0,         1, 32'h0,         0, 32'h0, 0));
    directed_rows.push_back(row(OP_MERGE,   63, 32'h0,         1, 32'h0,         0, 32'h0, 64));
    directed_rows.push_back(row(OP_SET,     62, 32'hFFFF_FFFF, 1, 32'h0, 1, 32'hFFFF_FFFF, 64));
    directed_rows.push_back(row(OP_SET,     62, 32'h0,         1, 32'hFFFF_FFFF, 0, 32'h0, 64));
    directed_rows.push_back(row(OP_CLEAR,   0,  32'h0,         1, 32'h0,         0, 32'h0, 0));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      d = directed_rows[i];
      issue(d.op, d.site, d.clk, d.typed, d.want);
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        if (idle_pct[ph] != 0 && $urandom_range(0, 99) < idle_pct[ph])
          rest($urandom_range(1, 4));
        else if ($urandom_range(0, 199) == 0)
          drain();
        random_item();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Ran %0d items (%0d table walks, %0d clears) over four pacing phases;",
             n_items, n_walks, n_clears);
    $display("compared %0d results, %0d field mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
